// ===== rtl/i2cmb_pkg.sv =====
package i2cmb_pkg;

	localparam int unsigned BitsPerByte  = 8;
	localparam int unsigned AckHoldTicks = 2;

	localparam logic [15:0] LongHoldReset  = 16'd5;
	localparam logic [15:0] ShortHoldReset = 16'd1;
	localparam logic [7:0]  AckPollReset   = 8'd8;

	// register indexes on the configuration port
	localparam logic [1:0] REG_LONG_HOLD  = 2'd0;
	localparam logic [1:0] REG_SHORT_HOLD = 2'd1;
	localparam logic [1:0] REG_ACK_POLL   = 2'd2;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_STOP  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [15:0] {
		PH_IDLE     = 16'h0001,
		PH_ST_SETUP = 16'h0002,
		PH_ST_HOLD  = 16'h0004,
		PH_SP_SETUP = 16'h0008,
		PH_SP_HOLD  = 16'h0010,
		PH_WR_LOW   = 16'h0020,
		PH_WR_HIGH  = 16'h0040,
		PH_WR_REL   = 16'h0080,
		PH_WR_POLL  = 16'h0100,
		PH_WR_AHOLD = 16'h0200,
		PH_WR_TAIL  = 16'h0400,
		PH_RD_REL   = 16'h0800,
		PH_RD_HIGH  = 16'h1000,
		PH_RD_LOW   = 16'h2000,
		PH_RD_ASET  = 16'h4000,
		PH_RD_AHIGH = 16'h8000
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] action;
		logic [7:0] write_data;
		logic       send_nack;
		logic       sda_sample;
	} tick_t;

	typedef struct packed {
		logic [15:0] long_hold;
		logic [15:0] short_hold;
		logic [7:0]  ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_seen;
	} res_t;

endpackage

// ===== rtl/i2cmb_step.sv =====
module i2cmb_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  i2cmb_pkg::tick_t tick,
	input  i2cmb_pkg::cfg_t  cfg,
	output i2cmb_pkg::res_t  res
);

	i2cmb_pkg::phase_t phase_q, phase_d;
	logic [15:0] timer_q, timer_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  poll_q, poll_d;
	logic        ack_q, ack_d;
	logic        nack_q, nack_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;

	logic [15:0] lng, sht;
	logic [7:0]  shift_nx;
	logic [3:0]  bit_nx;
	logic        done;
	logic [7:0]  rd_out;
	logic        ack_out;

	// a zero hold acts as one tick
	assign lng = (cfg.long_hold == 16'd0) ? 16'd1 : cfg.long_hold;
	assign sht = (cfg.short_hold == 16'd0) ? 16'd1 : cfg.short_hold;

	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		poll_d   = poll_q;
		ack_d    = ack_q;
		nack_d   = nack_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		done     = 1'b0;
		rd_out   = 8'd0;
		ack_out  = 1'b0;
		shift_nx = {shift_q[6:0], 1'b0};
		bit_nx   = bit_q + 4'd1;

		if (phase_q == i2cmb_pkg::PH_IDLE) begin
			if (tick.cmd_valid) begin
				case (i2cmb_pkg::action_t'(tick.action))
					i2cmb_pkg::ACT_START: begin
						phase_d = i2cmb_pkg::PH_ST_SETUP; timer_d = lng;
						scl_d = 1'b1; sda_d = 1'b1;
					end
					i2cmb_pkg::ACT_STOP: begin
						phase_d = i2cmb_pkg::PH_SP_SETUP; timer_d = lng;
						scl_d = 1'b1; sda_d = 1'b0;
					end
					i2cmb_pkg::ACT_WRITE: begin
						shift_d = tick.write_data; bit_d = 4'd0; ack_d = 1'b0;
						phase_d = i2cmb_pkg::PH_WR_LOW; timer_d = sht;
						scl_d = 1'b0; sda_d = tick.write_data[7];
					end
					default: begin
						shift_d = 8'd0; bit_d = 4'd0; nack_d = tick.send_nack;
						phase_d = i2cmb_pkg::PH_RD_REL; timer_d = sht;
						scl_d = 1'b0; sda_d = 1'b1;
					end
				endcase
			end
		end else if (phase_q == i2cmb_pkg::PH_WR_POLL) begin
			if (!tick.sda_sample || poll_q >= cfg.ack_poll_limit) begin
				if (!tick.sda_sample) begin
					ack_d = 1'b1;
				end
				phase_d = i2cmb_pkg::PH_WR_AHOLD;
				timer_d = 16'(i2cmb_pkg::AckHoldTicks);
				scl_d = 1'b1; sda_d = 1'b1;
			end else begin
				poll_d = poll_q + 8'd1;
			end
		end else if (timer_q > 16'd1) begin
			timer_d = timer_q - 16'd1;
		end else begin
			case (phase_q)
				i2cmb_pkg::PH_ST_SETUP: begin
					phase_d = i2cmb_pkg::PH_ST_HOLD; timer_d = lng;
					scl_d = 1'b1; sda_d = 1'b0;
				end
				i2cmb_pkg::PH_SP_SETUP: begin
					phase_d = i2cmb_pkg::PH_SP_HOLD; timer_d = lng;
					scl_d = 1'b1; sda_d = 1'b1;
				end
				i2cmb_pkg::PH_ST_HOLD: begin
					phase_d = i2cmb_pkg::PH_IDLE; timer_d = 16'd0;
					scl_d = 1'b0; sda_d = 1'b0; done = 1'b1;
				end
				i2cmb_pkg::PH_SP_HOLD: begin
					phase_d = i2cmb_pkg::PH_IDLE; timer_d = 16'd0;
					scl_d = 1'b1; sda_d = 1'b1; done = 1'b1;
				end
				i2cmb_pkg::PH_WR_LOW: begin
					phase_d = i2cmb_pkg::PH_WR_HIGH; timer_d = lng;
					scl_d = 1'b1;
				end
				i2cmb_pkg::PH_WR_HIGH: begin
					shift_d = shift_nx;
					bit_d   = bit_nx;
					if (bit_nx < 4'(i2cmb_pkg::BitsPerByte)) begin
						phase_d = i2cmb_pkg::PH_WR_LOW; timer_d = sht;
						scl_d = 1'b0; sda_d = shift_nx[7];
					end else begin
						phase_d = i2cmb_pkg::PH_WR_REL; timer_d = lng;
						scl_d = 1'b0; sda_d = 1'b1;
					end
				end
				i2cmb_pkg::PH_WR_REL: begin
					poll_d  = 8'd0;
					phase_d = i2cmb_pkg::PH_WR_POLL; timer_d = 16'd0;
					scl_d = 1'b1; sda_d = 1'b1;
				end
				i2cmb_pkg::PH_WR_AHOLD: begin
					phase_d = i2cmb_pkg::PH_WR_TAIL; timer_d = lng;
					scl_d = 1'b0; sda_d = 1'b0;
				end
				i2cmb_pkg::PH_WR_TAIL: begin
					phase_d = i2cmb_pkg::PH_IDLE; timer_d = 16'd0;
					scl_d = 1'b0; sda_d = 1'b0; done = 1'b1;
					ack_out = ack_q;
				end
				i2cmb_pkg::PH_RD_REL: begin
					phase_d = i2cmb_pkg::PH_RD_HIGH; timer_d = sht;
					scl_d = 1'b1; sda_d = 1'b1;
				end
				i2cmb_pkg::PH_RD_HIGH: begin
					// sample SDA as the high phase ends
					shift_d = {shift_q[6:0], tick.sda_sample};
					bit_d   = bit_nx;
					phase_d = i2cmb_pkg::PH_RD_LOW; timer_d = sht;
					scl_d = 1'b0; sda_d = 1'b1;
				end
				i2cmb_pkg::PH_RD_LOW: begin
					timer_d = sht;
					scl_d   = 1'b0;
					if (bit_q < 4'(i2cmb_pkg::BitsPerByte)) begin
						phase_d = i2cmb_pkg::PH_RD_REL; sda_d = 1'b1;
					end else begin
						phase_d = i2cmb_pkg::PH_RD_ASET; sda_d = nack_q;
					end
				end
				i2cmb_pkg::PH_RD_ASET: begin
					phase_d = i2cmb_pkg::PH_RD_AHIGH; timer_d = lng;
					scl_d = 1'b1; sda_d = nack_q;
				end
				i2cmb_pkg::PH_RD_AHIGH: begin
					phase_d = i2cmb_pkg::PH_IDLE; timer_d = 16'd0;
					scl_d = 1'b0; sda_d = nack_q; done = 1'b1;
					rd_out = shift_q;
				end
				default: begin
					phase_d = i2cmb_pkg::PH_IDLE; timer_d = 16'd0;
					done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cmb_pkg::PH_IDLE;
			timer_q <= 16'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			poll_q  <= 8'd0;
			ack_q   <= 1'b0;
			nack_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (en) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			poll_q  <= poll_d;
			ack_q   <= ack_d;
			nack_q  <= nack_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

	assign res.scl_level = scl_d;
	assign res.sda_level = sda_d;
	assign res.busy_res  = (phase_d != i2cmb_pkg::PH_IDLE);
	assign res.done_res  = done;
	assign res.read_data = rd_out;
	assign res.ack_seen  = ack_out;

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// Ticks pass through the input register, then the result register.
// Throughput: one tick per cycle unless the result slot stalls; the input
// register refills in the same cycle its tick enters the result register.
// Reset (arst_n low, asynchronous): bus idle with SCL and SDA released,
// hold registers back to 5 and 1 ticks, acknowledge poll limit back to 8.
module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	// tick channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd_valid,
	input  logic [1:0]  action,
	input  logic [7:0]  write_data,
	input  logic        send_nack,
	input  logic        sda_sample,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_seen,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers
	i2cmb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_hold      <= i2cmb_pkg::LongHoldReset;
			cfg_q.short_hold     <= i2cmb_pkg::ShortHoldReset;
			cfg_q.ack_poll_limit <= i2cmb_pkg::AckPollReset;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cmb_pkg::REG_LONG_HOLD:  cfg_q.long_hold      <= cfg_data;
				i2cmb_pkg::REG_SHORT_HOLD: cfg_q.short_hold     <= cfg_data;
				i2cmb_pkg::REG_ACK_POLL:   cfg_q.ack_poll_limit <= cfg_data[7:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// Input register: holds one tick until the result slot can take it.
	logic             valid_s1;
	i2cmb_pkg::tick_t tick_s1;
	logic             step_en;

	// The result slot is free when empty or being emptied this cycle.
	assign step_en  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1.cmd_valid  <= cmd_valid;
			tick_s1.action     <= action;
			tick_s1.write_data <= write_data;
			tick_s1.send_nack  <= send_nack;
			tick_s1.sda_sample <= sda_sample;
		end
	end

	// Bus sequencer: advance by one tick whenever the result slot accepts.
	i2cmb_pkg::res_t res_c;

	i2cmb_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.tick   (tick_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	// Result register
	logic            valid_s2;
	i2cmb_pkg::res_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_en) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid = valid_s2;
	assign scl_level = res_s2.scl_level;
	assign sda_level = res_s2.sda_level;
	assign busy_res  = res_s2.busy_res;
	assign done_res  = res_s2.done_res;
	assign read_data = res_s2.read_data;
	assign ack_seen  = res_s2.ack_seen;

	// A completing transfer always leaves the sequencer idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done pulse while still busy");

	// Read byte and acknowledge are shown only on a done tick.
	a_payload_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ack_seen || read_data != 8'd0) |-> done_res)
		else $error("read data or acknowledge outside a done tick");

	// With the result slot empty the tick channel never stalls.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("tick channel stalled with result slot empty");

	// A stepped tick always lands in the result slot.
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid)
		else $error("stepped tick lost");

endmodule

// ===== tb/tb_i2c_master_byte_engine.sv =====
module tb_i2c_master_byte_engine;
	import i2cmb_pkg::*;

	// A cycle count with no transfer on either channel that ends the run.
	localparam int WatchdogLimit = 2000;
	// Acknowledge sample index that never comes: the slave stays silent.
	localparam int SilentSlave = 1000;

	// Shadow of the engine's bus sequencer.
	typedef struct packed {
		phase_t      ph;
		logic [15:0] timer;
		logic [3:0]  bit_idx;
		logic [7:0]  shreg;
		logic [7:0]  polls;
		logic        ack_flag;
		logic        nack;
		logic        scl;
		logic        sda;
	} bus_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd_valid = 1'b0;
	logic [1:0]  action = ACT_START;
	logic [7:0]  write_data = 8'd0;
	logic        send_nack = 1'b0;
	logic        sda_sample = 1'b1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        scl_level;
	logic        sda_level;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        ack_seen;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_LONG_HOLD;
	logic [15:0] cfg_data = 16'd0;

	// Ticks waiting to be sent, and the pin results that the accepted ticks must produce.
	tick_t      pending_ticks[$];
	res_t       expected_pins[$];
	// plan_bus runs ahead as the ticks are queued; pred_bus follows the accepted ticks.
	bus_state_t plan_bus;
	bus_state_t pred_bus;
	cfg_t       bus_cfg;

	int fail_count = 0;
	int ticks_checked = 0;
	int completions = 0;
	int acks_seen = 0;
	int n_start = 0;
	int n_stop = 0;
	int n_write = 0;
	int n_read = 0;
	int planned_ticks = 0;

	i2c_master_byte_engine i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd_valid  (cmd_valid),
		.action     (action),
		.write_data (write_data),
		.send_nack  (send_nack),
		.sda_sample (sda_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.ack_seen   (ack_seen),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bus_state_t bus_idle_state();
		bus_state_t s;
		s = '0;
		s.ph = PH_IDLE;
		s.scl = 1'b1;
		s.sda = 1'b1;
		return s;
	endfunction

	function automatic void bus_enter(inout bus_state_t s, input phase_t ph,
			input logic [15:0] dur, input logic scl, input logic sda);
		s.ph = ph;
		s.timer = dur;
		s.scl = scl;
		s.sda = sda;
	endfunction

	// Advance the bus sequencer by one tick and return the pin result of that tick.
	function automatic res_t bus_tick(inout bus_state_t s, input cfg_t c, input tick_t t);
		res_t        r;
		logic [15:0] lng;
		logic [15:0] sht;
		// a hold of zero counts as one tick
		lng = (c.long_hold == 16'd0) ? 16'd1 : c.long_hold;
		sht = (c.short_hold == 16'd0) ? 16'd1 : c.short_hold;
		r = '0;
		if (s.ph == PH_IDLE) begin
			// commands are taken only here; while busy they are dropped
			if (t.cmd_valid) begin
				case (action_t'(t.action))
				ACT_START: bus_enter(s, PH_ST_SETUP, lng, 1'b1, 1'b1);
				ACT_STOP: bus_enter(s, PH_SP_SETUP, lng, 1'b1, 1'b0);
				ACT_WRITE: begin
					s.shreg = t.write_data;
					s.bit_idx = '0;
					s.ack_flag = 1'b0;
					bus_enter(s, PH_WR_LOW, sht, 1'b0, t.write_data[7]);
				end
				default: begin
					s.shreg = '0;
					s.bit_idx = '0;
					s.nack = t.send_nack;
					bus_enter(s, PH_RD_REL, sht, 1'b0, 1'b1);
				end
				endcase
			end
		end else if (s.ph == PH_WR_POLL) begin
			// low SDA is an acknowledge; high SDA at the poll limit gives up
			if (!t.sda_sample) begin
				s.ack_flag = 1'b1;
				bus_enter(s, PH_WR_AHOLD, 16'(AckHoldTicks), 1'b1, 1'b1);
			end else if (s.polls >= c.ack_poll_limit) begin
				bus_enter(s, PH_WR_AHOLD, 16'(AckHoldTicks), 1'b1, 1'b1);
			end else begin
				s.polls = s.polls + 8'd1;
			end
		end else if (s.timer > 16'd1) begin
			s.timer = s.timer - 16'd1;
		end else begin
			case (s.ph)
			PH_ST_SETUP: bus_enter(s, PH_ST_HOLD, lng, 1'b1, 1'b0);
			PH_ST_HOLD: bus_enter(s, PH_IDLE, 16'd0, 1'b0, 1'b0);
			PH_SP_SETUP: bus_enter(s, PH_SP_HOLD, lng, 1'b1, 1'b1);
			PH_SP_HOLD: bus_enter(s, PH_IDLE, 16'd0, 1'b1, 1'b1);
			PH_WR_LOW: bus_enter(s, PH_WR_HIGH, lng, 1'b1, s.sda);
			PH_WR_HIGH: begin
				s.shreg = s.shreg << 1;
				s.bit_idx = s.bit_idx + 4'd1;
				if (s.bit_idx < BitsPerByte)
					bus_enter(s, PH_WR_LOW, sht, 1'b0, s.shreg[7]);
				else
					bus_enter(s, PH_WR_REL, lng, 1'b0, 1'b1);
			end
			PH_WR_REL: begin
				s.polls = '0;
				bus_enter(s, PH_WR_POLL, 16'd0, 1'b1, 1'b1);
			end
			PH_WR_AHOLD: bus_enter(s, PH_WR_TAIL, lng, 1'b0, 1'b0);
			PH_WR_TAIL: begin
				bus_enter(s, PH_IDLE, 16'd0, 1'b0, 1'b0);
				r.ack_seen = s.ack_flag;
			end
			PH_RD_REL: bus_enter(s, PH_RD_HIGH, sht, 1'b1, 1'b1);
			PH_RD_HIGH: begin
				// sample SDA as the SCL high phase ends
				s.shreg = {s.shreg[6:0], t.sda_sample};
				s.bit_idx = s.bit_idx + 4'd1;
				bus_enter(s, PH_RD_LOW, sht, 1'b0, 1'b1);
			end
			PH_RD_LOW: begin
				if (s.bit_idx < BitsPerByte)
					bus_enter(s, PH_RD_REL, sht, 1'b0, 1'b1);
				else
					bus_enter(s, PH_RD_ASET, sht, 1'b0, s.nack);
			end
			PH_RD_ASET: bus_enter(s, PH_RD_AHIGH, lng, 1'b1, s.nack);
			PH_RD_AHIGH: begin
				bus_enter(s, PH_IDLE, 16'd0, 1'b0, s.nack);
				r.read_data = s.shreg;
			end
			default: bus_enter(s, PH_IDLE, 16'd0, s.scl, s.sda);
			endcase
			// only the end of a command brings the sequencer back to idle here
			r.done_res = (s.ph == PH_IDLE);
		end
		r.scl_level = s.scl;
		r.sda_level = s.sda;
		r.busy_res = (s.ph != PH_IDLE);
		return r;
	endfunction

	// Mostly back to back, sometimes a short pause, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	function automatic tick_t random_tick();
		logic [31:0] bits;
		bits = $urandom;
		return bits[12:0];
	endfunction

	task automatic queue_tick(input tick_t t);
		pending_ticks.push_back(t);
		void'(bus_tick(plan_bus, bus_cfg, t));
		planned_ticks++;
	endtask

	task automatic queue_idle(input int n);
		tick_t t;
		for (int i = 0; i < n; i++) begin
			t = random_tick();
			t.cmd_valid = 1'b0;
			queue_tick(t);
		end
	endtask

	// Queue one command and the ticks that carry it through to its done tick.
	// The slave acknowledges on poll sample ack_at; busy ticks carry a
	// dropped command with the given chance in percent.
	task automatic queue_command(input action_t act, input logic [7:0] data,
			input logic nack, input int ack_at, input int noise_pct);
		tick_t t;
		t = random_tick();
		t.cmd_valid = 1'b1;
		t.action = act;
		t.write_data = data;
		t.send_nack = nack;
		queue_tick(t);
		case (act)
		ACT_START: n_start++;
		ACT_STOP: n_stop++;
		ACT_WRITE: n_write++;
		default: n_read++;
		endcase
		while (plan_bus.ph != PH_IDLE) begin
			t = random_tick();
			t.cmd_valid = ($urandom_range(0, 99) < noise_pct);
			if (plan_bus.ph == PH_WR_POLL)
				t.sda_sample = (int'(plan_bus.polls) == ack_at) ? 1'b0 : 1'b1;
			queue_tick(t);
		end
	endtask

	// Random command mix until about n ticks are queued; ends with the bus idle.
	task automatic queue_random_commands(input int n);
		int      first;
		int      r;
		int      ack_at;
		int      lim;
		action_t act;
		first = planned_ticks;
		while (planned_ticks - first < n) begin
			queue_idle(($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2));
			r = $urandom_range(0, 99);
			act = (r < 20) ? ACT_START : (r < 40) ? ACT_STOP : (r < 72) ? ACT_WRITE : ACT_READ;
			lim = int'(bus_cfg.ack_poll_limit);
			case ($urandom_range(0, 5))
			0: ack_at = 0;
			1: ack_at = lim;
			2: ack_at = lim + 1;
			3: ack_at = SilentSlave;
			default: ack_at = $urandom_range(0, lim);
			endcase
			queue_command(act, 8'($urandom), 1'($urandom),
				ack_at, ($urandom_range(0, 3) == 0) ? 30 : 0);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_LONG_HOLD: bus_cfg.long_hold = val;
		REG_SHORT_HOLD: bus_cfg.short_hold = val;
		default: bus_cfg.ack_poll_limit = val[7:0];
		endcase
	endtask

	task automatic write_all_regs(input logic [15:0] lng, input logic [15:0] sht,
			input logic [7:0] lim);
		write_reg(REG_LONG_HOLD, lng);
		write_reg(REG_SHORT_HOLD, sht);
		write_reg(REG_ACK_POLL, {8'd0, lim});
	endtask

	// Wait for every queued tick to be sent and every result to come back,
	// then let the pipeline run on idle before returning.
	task automatic drain();
		while (pending_ticks.size() != 0 || in_valid || expected_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Tick channel driver: predict each tick as it transfers, then present the
	// next one after a random gap.
	always @(posedge clk or negedge arst_n) begin : tick_driver
		tick_t    nxt;
		int       gap;
		bit       no_gaps;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_pins.push_back(bus_tick(pred_bus, bus_cfg,
					{cmd_valid, action, write_data, send_nack, sda_sample}));
			if (!in_valid || in_ready) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					nxt = pending_ticks.pop_front();
					in_valid <= 1'b1;
					cmd_valid <= nxt.cmd_valid;
					action <= nxt.action;
					write_data <= nxt.write_data;
					send_nack <= nxt.send_nack;
					sda_sample <= nxt.sda_sample;
					// switch between stretches with and without gaps now and then
					if ($urandom_range(0, 199) == 0)
						no_gaps = !no_gaps;
					gap = no_gaps ? 0 : gap_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result channel monitor: compare each transfer with the oldest prediction
	// and stall at random.
	always @(posedge clk or negedge arst_n) begin : pin_monitor
		res_t got;
		res_t want;
		int   stall;
		bit   no_stalls;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {scl_level, sda_level, busy_res, done_res, read_data, ack_seen};
				if (expected_pins.size() == 0) begin
					$error("result transfer with no tick outstanding");
					fail_count++;
				end else begin
					want = expected_pins.pop_front();
					ticks_checked++;
					if (want.done_res)
						completions++;
					if (want.ack_seen)
						acks_seen++;
					if (got.scl_level !== want.scl_level) begin
						$error("scl_level: expected %0d, actual %0d", want.scl_level, got.scl_level);
						fail_count++;
					end
					if (got.sda_level !== want.sda_level) begin
						$error("sda_level: expected %0d, actual %0d", want.sda_level, got.sda_level);
						fail_count++;
					end
					if (got.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
						fail_count++;
					end
					if (got.done_res !== want.done_res) begin
						$error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
						fail_count++;
					end
					if (got.read_data !== want.read_data) begin
						$error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
						fail_count++;
					end
					if (got.ack_seen !== want.ack_seen) begin
						$error("ack_seen: expected %0d, actual %0d", want.ack_seen, got.ack_seen);
						fail_count++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 199) == 0)
					no_stalls = !no_stalls;
				stall = no_stalls ? 0 : gap_length();
			end
		end
	end

	// Drop the run if neither channel has had a transfer for too long.
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WatchdogLimit) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		plan_bus = bus_idle_state();
		pred_bus = bus_idle_state();
		bus_cfg = '{long_hold: LongHoldReset, short_hold: ShortHoldReset,
			ack_poll_limit: AckPollReset};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands at the reset settings: a stop from a released
		// bus, writes acknowledged at the first and at the last poll sample
		// and one never acknowledged, reads answering ACK and NACK, and
		// commands offered while busy.
		queue_command(ACT_STOP, 8'h00, 1'b0, SilentSlave, 0);
		queue_command(ACT_START, 8'h00, 1'b0, SilentSlave, 0);
		queue_command(ACT_WRITE, 8'hFF, 1'b0, 0, 0);
		queue_command(ACT_WRITE, 8'h00, 1'b1, SilentSlave, 0);
		queue_command(ACT_WRITE, 8'hA5, 1'b0, int'(AckPollReset), 0);
		queue_command(ACT_READ, 8'h00, 1'b0, SilentSlave, 0);
		queue_command(ACT_READ, 8'hFF, 1'b1, SilentSlave, 0);
		queue_command(ACT_WRITE, 8'h5A, 1'b1, 3, 100);
		queue_command(ACT_READ, 8'h3C, 1'b1, SilentSlave, 50);
		queue_command(ACT_STOP, 8'h00, 1'b0, SilentSlave, 100);
		queue_idle(3);
		drain();

		// Zero holds act as one tick; a zero poll limit takes a single sample.
		write_all_regs(16'd0, 16'd0, 8'd0);
		queue_random_commands(200);
		drain();

		// Widest acknowledge window.
		write_all_regs(16'd3, 16'd2, 8'd255);
		queue_random_commands(250);
		drain();

		repeat (4) begin
			write_all_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
				8'($urandom_range(0, 12)));
			queue_random_commands(120);
			drain();
		end

		// Longer holds: a single start keeps the bus busy for the long hold
		// count twice.
		write_all_regs(16'd40, 16'd12, 8'd1);
		queue_command(ACT_START, 8'h00, 1'b0, SilentSlave, 10);
		drain();

		$display("checked %0d ticks: %0d starts, %0d stops, %0d writes, %0d reads queued",
			ticks_checked, n_start, n_stop, n_write, n_read);
		$display("%0d commands completed, %0d writes acknowledged by the slave",
			completions, acks_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/i2cmb_pkg.sv
rtl/i2cmb_step.sv
rtl/i2c_master_byte_engine.sv
tb/tb_i2c_master_byte_engine.sv
